[hdl/candidate_reservoir_selector_defines.svh]
// Assertion macros shared by the candidate reservoir selector RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef CANDIDATE_RESERVOIR_SELECTOR_DEFINES_SVH
`define CANDIDATE_RESERVOIR_SELECTOR_DEFINES_SVH

// Same-cycle implication
`define CRS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("crs: same-cycle check failed");

// Next-cycle implication
`define CRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("crs: next-cycle check failed");

`endif

[hdl/crs_pkg.sv]
// Package for the candidate reservoir selector: widths, codes and the
// controller/datapath command and status types. Depends on nothing.
package crs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int OP_W       = 2;
    localparam int ID_W       = 10;
    localparam int BIRTH_W    = 16;
    localparam int FIT_W      = 32;
    localparam int RAND_W     = 16;
    localparam int CAP_W      = 5;
    localparam int MODE_W     = 2;
    localparam int METH_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int KEY_W      = ID_W + BIRTH_W;
    localparam int ENTRY_W    = KEY_W + FIT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_OFFER  = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Registration modes
    localparam logic [MODE_W-1:0] MODE_STRICT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd2;

    // Selection methods
    localparam logic [METH_W-1:0] METH_UNIFORM  = 2'd0;
    localparam logic [METH_W-1:0] METH_BEST     = 2'd1;
    localparam logic [METH_W-1:0] METH_ROULETTE = 2'd2;
    localparam logic [METH_W-1:0] METH_UNUSED   = 2'd3;

    // Selection status
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_AUTH    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRICT   = 3'd4;

    // Register reset values
    localparam logic [CAP_W-1:0]  CAP_RST    = 5'd16;
    localparam logic [MODE_W-1:0] MODE_RST   = MODE_REPEAT;
    localparam logic [METH_W-1:0] METHOD_RST = METH_BEST;

    // Datapath commands
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_IDX_CLR,
        CMD_CNT_CLR,
        CMD_RD_IDX,
        CMD_IDX_INC,
        CMD_WR_UPD,
        CMD_ACC_ALWAYS,
        CMD_J_SET,
        CMD_RD_JM1,
        CMD_WR_SHIFT,
        CMD_WR_NEW,
        CMD_DIV_CNT,
        CMD_SEL_REM,
        CMD_BEST_UPD,
        CMD_BEST_END,
        CMD_TIE_STEP,
        CMD_SUM_ACC,
        CMD_MUL,
        CMD_SEL_LAST,
        CMD_ROUL_STEP,
        CMD_RD_SEL,
        CMD_PICK,
        CMD_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              busy;
        logic              go;
        logic [METH_W-1:0] method;
        logic              idx_at_end;
        logic              key_eq;
        logic              key_gt;
        logic              full;
        logic              j_at_pos;
        logic              div_done;
        logic              rem_nz;
        logic              similar_nz;
        logic              tie_hit;
        logic              roul_hit;
        logic              out_free;
    } stat_t;

endpackage

[hdl/crs_if.sv]
// Channel interfaces of the candidate reservoir selector: request,
// response and configuration write. Depends on crs_pkg.
interface crs_req_if;
    import crs_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    sender_id;
    logic [BIRTH_W-1:0] sender_birth;
    logic [FIT_W-1:0]   cand_fitness;
    logic [FIT_W-1:0]   own_fitness;
    logic               busy_req;
    logic               timed_out;
    logic [RAND_W-1:0]  rand_value;

    modport source (output valid, op, sender_id, sender_birth, cand_fitness,
                    own_fitness, busy_req, timed_out, rand_value, input ready);
    modport sink (input valid, op, sender_id, sender_birth, cand_fitness,
                  own_fitness, busy_req, timed_out, rand_value, output ready);
endinterface

interface crs_rsp_if;
    import crs_pkg::*;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [STAT_W-1:0]  sel_status;
    logic [ID_W-1:0]    sel_id;
    logic [BIRTH_W-1:0] sel_birth;
    logic [FIT_W-1:0]   sel_fitness;

    modport source (output valid, accepted, sel_status, sel_id, sel_birth,
                    sel_fitness, input ready);
    modport sink (input valid, accepted, sel_status, sel_id, sel_birth,
                  sel_fitness, output ready);
endinterface

interface crs_cfg_if;
    import crs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/crs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module crs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[hdl/crs_mod_unit.sv]
// Iterative restoring remainder unit: random word modulo a small count,
// one quotient bit per cycle. Depends on crs_pkg.
module crs_mod_unit #(
    parameter int DW = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [crs_pkg::RAND_W-1:0] dividend,
    input  logic [DW-1:0]             divisor,
    output logic                      done,
    output logic [DW-1:0]             rem
);
    import crs_pkg::*;

    localparam int SW = $clog2(RAND_W);

    logic              run_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [RAND_W-1:0] dvd_reg;
    logic [DW-1:0]     dsr_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW:0]       trial;
    logic [DW:0]       diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(RAND_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, dsr_reg}) ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule

[hdl/crs_controller.sv]
// Sequencer of the candidate reservoir selector: walks the table through
// the datapath by commands. Depends on crs_pkg.
module crs_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  crs_pkg::stat_t stat,
    output crs_pkg::cmd_t  cmd
);
    import crs_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_DECODE   = 20'h00002,
        S_SRCH_RD  = 20'h00004,
        S_SRCH_CMP = 20'h00008,
        S_INS_CHK  = 20'h00010,
        S_SHIFT_RD = 20'h00020,
        S_SHIFT_WR = 20'h00040,
        S_DIV_U    = 20'h00080,
        S_BEST_RD  = 20'h00100,
        S_BEST_CMP = 20'h00200,
        S_BEST_DIV = 20'h00400,
        S_TIE_RD   = 20'h00800,
        S_TIE_CMP  = 20'h01000,
        S_SUM_RD   = 20'h02000,
        S_SUM_ADD  = 20'h04000,
        S_ROUL_RD  = 20'h08000,
        S_ROUL_CMP = 20'h10000,
        S_FETCH    = 20'h20000,
        S_PICK     = 20'h40000,
        S_FINISH   = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_OFFER:
                    begin
                        if (stat.busy)
                        begin
                            cmd.op     = CMD_ACC_ALWAYS;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = CMD_IDX_CLR;
                            state_next = S_SRCH_RD;
                        end
                    end
                    OP_SELECT:
                    begin
                        if (!stat.go)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (stat.method == METH_UNIFORM)
                        begin
                            cmd.op     = CMD_DIV_CNT;
                            state_next = S_DIV_U;
                        end
                        else if (stat.method == METH_BEST)
                        begin
                            cmd.op     = CMD_IDX_CLR;
                            state_next = S_BEST_RD;
                        end
                        else
                        begin
                            cmd.op     = CMD_IDX_CLR;
                            state_next = S_SUM_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.op     = CMD_CNT_CLR;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            // Key search in sorted order
            S_SRCH_RD:
            begin
                if (stat.idx_at_end)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.op     = CMD_RD_IDX;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.key_eq)
                begin
                    cmd.op     = CMD_WR_UPD;
                    state_next = S_FINISH;
                end
                else if (stat.key_gt)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.op     = CMD_IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            S_INS_CHK:
            begin
                if (stat.full)
                begin
                    cmd.op     = CMD_ACC_ALWAYS;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = CMD_J_SET;
                    state_next = S_SHIFT_RD;
                end
            end
            // Open a slot by moving the tail up one entry
            S_SHIFT_RD:
            begin
                if (stat.j_at_pos)
                begin
                    cmd.op     = CMD_WR_NEW;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = CMD_RD_JM1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = CMD_WR_SHIFT;
                state_next = S_SHIFT_RD;
            end
            S_DIV_U:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = CMD_SEL_REM;
                    state_next = S_FETCH;
                end
            end
            // Best fitness scan
            S_BEST_RD:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.op     = CMD_BEST_END;
                    state_next = stat.similar_nz ? S_BEST_DIV : S_FETCH;
                end
                else
                begin
                    cmd.op     = CMD_RD_IDX;
                    state_next = S_BEST_CMP;
                end
            end
            S_BEST_CMP:
            begin
                cmd.op     = CMD_BEST_UPD;
                state_next = S_BEST_RD;
            end
            S_BEST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_nz)
                    begin
                        cmd.op     = CMD_IDX_CLR;
                        state_next = S_TIE_RD;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            // Tie break: find the wanted equal entry
            S_TIE_RD:
            begin
                if (stat.idx_at_end)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = CMD_RD_IDX;
                    state_next = S_TIE_CMP;
                end
            end
            S_TIE_CMP:
            begin
                cmd.op     = CMD_TIE_STEP;
                state_next = stat.tie_hit ? S_FETCH : S_TIE_RD;
            end
            // Roulette: total first, then the running sum
            S_SUM_RD:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.op     = CMD_MUL;
                    state_next = S_ROUL_RD;
                end
                else
                begin
                    cmd.op     = CMD_RD_IDX;
                    state_next = S_SUM_ADD;
                end
            end
            S_SUM_ADD:
            begin
                cmd.op     = CMD_SUM_ACC;
                state_next = S_SUM_RD;
            end
            S_ROUL_RD:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.op     = CMD_SEL_LAST;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.op     = CMD_RD_IDX;
                    state_next = S_ROUL_CMP;
                end
            end
            S_ROUL_CMP:
            begin
                cmd.op     = CMD_ROUL_STEP;
                state_next = stat.roul_hit ? S_FETCH : S_ROUL_RD;
            end
            S_FETCH:
            begin
                cmd.op     = CMD_RD_SEL;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op     = CMD_PICK;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = CMD_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule

[hdl/crs_datapath.sv]
// Datapath of the candidate reservoir selector: config registers, entry
// table, scan registers, remainder unit and result register.
// Depends on crs_pkg, crs_ram, crs_mod_unit and the defines header.
`include "candidate_reservoir_selector_defines.svh"

module crs_datapath #(
    parameter int TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crs_pkg::cmd_t                 cmd,
    output crs_pkg::stat_t                stat,
    input  logic [crs_pkg::OP_W-1:0]      in_op,
    input  logic [crs_pkg::ID_W-1:0]      in_id,
    input  logic [crs_pkg::BIRTH_W-1:0]   in_birth,
    input  logic [crs_pkg::FIT_W-1:0]     in_fit,
    input  logic [crs_pkg::FIT_W-1:0]     in_own,
    input  logic                          in_busy,
    input  logic                          in_tmo,
    input  logic [crs_pkg::RAND_W-1:0]    in_rand,
    input  logic                          cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_accepted,
    output logic [crs_pkg::STAT_W-1:0]    out_status,
    output logic [crs_pkg::ID_W-1:0]      out_id,
    output logic [crs_pkg::BIRTH_W-1:0]   out_birth,
    output logic [crs_pkg::FIT_W-1:0]     out_fitness
);
    import crs_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int TW = FIT_W + AW;
    localparam int PW = TW + RAND_W;

    // Configuration
    logic [CAP_W-1:0]  cap_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [METH_W-1:0] meth_reg;
    logic              filt_reg;
    logic              strict_reg;

    // Table fill and output handshake
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;

    // Item and scan registers
    logic [OP_W-1:0]    op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [BIRTH_W-1:0] birth_reg;
    logic [FIT_W-1:0]   fit_reg;
    logic [FIT_W-1:0]   own_reg;
    logic               busy_reg;
    logic               tmo_reg;
    logic [RAND_W-1:0]  rnd_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      sel_reg;
    logic [CW-1:0]      best_idx_reg;
    logic [FIT_W-1:0]   best_val_reg;
    logic [CW-1:0]      similar_reg;
    logic [CW-1:0]      seen_reg;
    logic [TW-1:0]      total_reg;
    logic [TW-1:0]      run_reg;
    logic [PW-1:0]      target_reg;

    // Result under construction and presented result
    logic               res_acc_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [BIRTH_W-1:0] res_birth_reg;
    logic [FIT_W-1:0]   res_fit_reg;
    logic               out_acc_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [BIRTH_W-1:0] out_birth_reg;
    logic [FIT_W-1:0]   out_fit_reg;

    // RAM and remainder unit hookup
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] rd_data;
    logic [KEY_W-1:0]   rd_key;
    logic [FIT_W-1:0]   rd_fit;
    logic [CW-1:0]      jm1;
    logic               div_start;
    logic [CW-1:0]      div_dsr;
    logic               div_done;
    logic [CW-1:0]      div_rem;

    // Derived status
    logic [LW-1:0]      lim;
    logic               full;
    logic [TW-1:0]      run_nxt;
    logic               roul_hit;
    logic               fit_eq_best;
    logic               refused;

    assign rd_key      = rd_data[ENTRY_W-1:FIT_W];
    assign rd_fit      = rd_data[FIT_W-1:0];
    assign jm1         = j_reg - 1'b1;
    assign run_nxt     = run_reg + TW'(rd_fit);
    assign roul_hit    = {run_nxt, {RAND_W{1'b0}}} >= target_reg;
    assign fit_eq_best = (rd_fit == best_val_reg);
    assign refused     = filt_reg && (strict_reg ? (rd_fit <= own_reg) : (rd_fit < own_reg));

    // Effective capacity, clamped to 1..TABLE_DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (LW'(cap_reg) > LW'(TABLE_DEPTH))
        begin
            lim = LW'(TABLE_DEPTH);
        end
        else
        begin
            lim = LW'(cap_reg);
        end
    end
    assign full = (LW'(cnt_reg) >= lim);

    // Status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.busy       = busy_reg;
        stat.go         = !busy_reg && (meth_reg != METH_UNUSED)
                          && (full || ((cnt_reg != '0) && tmo_reg));
        stat.method     = meth_reg;
        stat.idx_at_end = (idx_reg == cnt_reg);
        stat.key_eq     = (rd_key == {id_reg, birth_reg});
        stat.key_gt     = (rd_key > {id_reg, birth_reg});
        stat.full       = full;
        stat.j_at_pos   = (j_reg == idx_reg);
        stat.div_done   = div_done;
        stat.rem_nz     = (div_rem != '0);
        stat.similar_nz = (similar_reg != '0);
        stat.tie_hit    = fit_eq_best && (seen_reg == div_rem);
        stat.roul_hit   = roul_hit;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Table port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = {id_reg, birth_reg, fit_reg};
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        case (cmd.op)
            CMD_RD_IDX:
            begin
                ram_re = 1'b1;
            end
            CMD_RD_JM1:
            begin
                ram_re    = 1'b1;
                ram_raddr = jm1[AW-1:0];
            end
            CMD_RD_SEL:
            begin
                ram_re    = 1'b1;
                ram_raddr = sel_reg[AW-1:0];
            end
            CMD_WR_UPD, CMD_WR_NEW:
            begin
                ram_we = 1'b1;
            end
            CMD_WR_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[AW-1:0];
                ram_wdata = rd_data;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign div_start = (cmd.op == CMD_DIV_CNT) || (cmd.op == CMD_BEST_END);
    assign div_dsr   = (cmd.op == CMD_DIV_CNT) ? cnt_reg : similar_reg;

    crs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    crs_mod_unit #(
        .DW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_reg),
        .divisor  (div_dsr),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Config, fill count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RST;
            mode_reg      <= MODE_RST;
            meth_reg      <= METHOD_RST;
            filt_reg      <= 1'b0;
            strict_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAPACITY: cap_reg    <= cfg_data[CAP_W-1:0];
                    REG_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_METHOD:   meth_reg   <= cfg_data[METH_W-1:0];
                    REG_FILTER:   filt_reg   <= cfg_data[0];
                    REG_STRICT:   strict_reg <= cfg_data[0];
                    default:      cap_reg    <= cap_reg;
                endcase
            end
            if ((cmd.op == CMD_CNT_CLR) || (cmd.op == CMD_PICK))
            begin
                cnt_reg <= '0;
            end
            else if (cmd.op == CMD_WR_NEW)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.op == CMD_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                op_reg         <= in_op;
                id_reg         <= in_id;
                birth_reg      <= in_birth;
                fit_reg        <= in_fit;
                own_reg        <= in_own;
                busy_reg       <= in_busy;
                tmo_reg        <= in_tmo;
                rnd_reg        <= in_rand;
                res_acc_reg    <= 1'b0;
                res_status_reg <= ST_NONE;
                res_id_reg     <= '0;
                res_birth_reg  <= '0;
                res_fit_reg    <= '0;
            end
            CMD_IDX_CLR:
            begin
                idx_reg   <= '0;
                seen_reg  <= '0;
                total_reg <= '0;
            end
            CMD_IDX_INC:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            CMD_WR_UPD:
            begin
                res_acc_reg <= (mode_reg != MODE_STRICT);
            end
            CMD_ACC_ALWAYS:
            begin
                res_acc_reg <= (mode_reg == MODE_ALWAYS);
            end
            CMD_J_SET:
            begin
                j_reg <= cnt_reg;
            end
            CMD_WR_SHIFT:
            begin
                j_reg <= jm1;
            end
            CMD_WR_NEW:
            begin
                res_acc_reg <= 1'b1;
            end
            CMD_SEL_REM:
            begin
                sel_reg <= div_rem;
            end
            // Highest fitness; first entry seeds the scan
            CMD_BEST_UPD:
            begin
                if ((idx_reg == '0) || (rd_fit > best_val_reg))
                begin
                    best_idx_reg <= idx_reg;
                    best_val_reg <= rd_fit;
                    similar_reg  <= '0;
                end
                else if (fit_eq_best)
                begin
                    similar_reg <= similar_reg + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            CMD_BEST_END:
            begin
                sel_reg <= best_idx_reg;
            end
            CMD_TIE_STEP:
            begin
                if (fit_eq_best)
                begin
                    if (seen_reg == div_rem)
                    begin
                        sel_reg <= idx_reg;
                    end
                    seen_reg <= seen_reg + 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            CMD_SUM_ACC:
            begin
                total_reg <= total_reg + TW'(rd_fit);
                idx_reg   <= idx_reg + 1'b1;
            end
            CMD_MUL:
            begin
                target_reg <= PW'(rnd_reg) * PW'(total_reg);
                idx_reg    <= '0;
                run_reg    <= '0;
            end
            CMD_SEL_LAST:
            begin
                sel_reg <= cnt_reg - 1'b1;
            end
            CMD_ROUL_STEP:
            begin
                run_reg <= run_nxt;
                if (roul_hit)
                begin
                    sel_reg <= idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            CMD_PICK:
            begin
                res_id_reg     <= rd_data[ENTRY_W-1:KEY_W + FIT_W - ID_W];
                res_birth_reg  <= rd_data[FIT_W + BIRTH_W - 1:FIT_W];
                res_fit_reg    <= rd_fit;
                res_status_reg <= refused ? ST_REFUSED : ST_AUTH;
            end
            CMD_OUT_LOAD:
            begin
                out_acc_reg    <= res_acc_reg;
                out_status_reg <= res_status_reg;
                out_id_reg     <= res_id_reg;
                out_birth_reg  <= res_birth_reg;
                out_fit_reg    <= res_fit_reg;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_accepted = out_acc_reg;
    assign out_status   = out_status_reg;
    assign out_id       = out_id_reg;
    assign out_birth    = out_birth_reg;
    assign out_fitness  = out_fit_reg;

    // Checks
    `CRS_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.op == CMD_WR_NEW, cnt_reg == $past(cnt_reg) + 1'b1)
    `CRS_ASSERT_NEXT(a_pick_empties, clk, rst_n, cmd.op == CMD_PICK, cnt_reg == '0)
    `CRS_ASSERT_NOW(a_sel_in_table, clk, rst_n, cmd.op == CMD_RD_SEL, sel_reg < cnt_reg)
endmodule

[hdl/candidate_reservoir_selector.sv]
// Top level of the candidate reservoir selector: controller plus datapath.
// Depends on crs_pkg, crs_if, crs_controller and crs_datapath.
//
// One item is in work at a time; the next is taken once the result is in
// the output register. An offer takes longer the more entries it searches and,
// for an insert, moves; a best select scans every stored entry, and a roulette
// select sums every entry, then scans up to the chosen one. The registered-read
// entry RAM makes each entry visited a read then a use, and a uniform pick or a
// best pick with ties runs the bit-serial remainder unit (16 steps). A stalled
// output register adds its wait. Configuration writes are taken any time.
module candidate_reservoir_selector #(
    parameter int TABLE_DEPTH = crs_pkg::TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    crs_req_if.sink   req,
    crs_rsp_if.source rsp,
    crs_cfg_if.sink   cfg
);
    import crs_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    crs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (req.op),
        .in_id        (req.sender_id),
        .in_birth     (req.sender_birth),
        .in_fit       (req.cand_fitness),
        .in_own       (req.own_fitness),
        .in_busy      (req.busy_req),
        .in_tmo       (req.timed_out),
        .in_rand      (req.rand_value),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_accepted (rsp.accepted),
        .out_status   (rsp.sel_status),
        .out_id       (rsp.sel_id),
        .out_birth    (rsp.sel_birth),
        .out_fitness  (rsp.sel_fitness)
    );
endmodule
